>>> rtl/prewitt_edge_magnitude_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Prewitt edge magnitude block
// Clocked checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef PREWITT_EDGE_MAGNITUDE_TOP_MACROS_SVH
`define PREWITT_EDGE_MAGNITUDE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define PEM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pem assertion failed");

// Next-cycle implication
`define PEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pem assertion failed");

`else

`define PEM_ASSERT_NOW(lbl, ante, cons)
`define PEM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/pem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pem_pkg
// Constants, types and the kernel function of the Prewitt edge magnitude block.
// ---------------------------------------------------------------------------
package pem_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int WDIM_W = COL_W + 1;

  localparam int CFG_W  = 8;
  localparam int PIX_IN_W = 16;
  localparam int PIX_W  = 8;
  localparam int MAG_W  = 11;
  localparam int OUT_TDATA_W = 16;

  // compare widths big enough for both the register and the bounds
  localparam int WCMP_W = (CFG_W > WDIM_W) ? CFG_W : WDIM_W;
  localparam int HCMP_W = (CFG_W > ROW_W) ? CFG_W : ROW_W;

  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(128);
  localparam logic [PIX_IN_W-1:0] PIX_MAX = PIX_IN_W'(255);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             last;
    logic             frame_done;
  } result_t;

  // |Gx| + |Gy|; Gx = left minus right column, Gy = bottom minus top row
  function automatic logic [MAG_W-1:0] prewitt_mag(column_t lc, column_t cc, column_t rc);
    logic signed [MAG_W-1:0] gx;
    logic signed [MAG_W-1:0] gy;
    logic        [MAG_W-1:0] ax;
    logic        [MAG_W-1:0] ay;
    gx = $signed(MAG_W'(lc.top) + MAG_W'(lc.mid) + MAG_W'(lc.bot))
       - $signed(MAG_W'(rc.top) + MAG_W'(rc.mid) + MAG_W'(rc.bot));
    gy = $signed(MAG_W'(lc.bot) + MAG_W'(cc.bot) + MAG_W'(rc.bot))
       - $signed(MAG_W'(lc.top) + MAG_W'(cc.top) + MAG_W'(rc.top));
    ax = gx[MAG_W-1] ? MAG_W'(-gx) : MAG_W'(gx);
    ay = gy[MAG_W-1] ? MAG_W'(-gy) : MAG_W'(gy);
    return ax + ay;
  endfunction

endpackage
`default_nettype wire

>>> rtl/prewitt_edge_magnitude_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prewitt_edge_magnitude_top
// Streaming 3x3 Prewitt edge magnitude over a raster pixel stream.
// ---------------------------------------------------------------------------
// Pixels come in on the s_axis request channel in raster order, one per
// request; tuser high marks a flush item (a zero pixel). After the rows of a
// frame, image_width flush items drive out the results of the bottom row.
// Results |Gx|+|Gy| leave on m_axis; tlast marks the final result of an
// input request, tuser marks the bottom-right pixel of the frame.
// Results lag one row and one column; row 0 gives none, the last column
// of each later row gives two.
// Timing: a request is held in the input register and then enters the
// result queue, from which its first result can be taken; the second
// result of a last column follows it out of the queue.
// Throughput: one request per cycle with no stall while the receiver is
// ready; the extra result of the last column is balanced by the first
// column, which gives none, and the two-entry queue absorbs it.
// When the receiver stalls the queue fills; input stops once the queue has
// no room for the results of the request held in the input register.
// Reset (rst, synchronous) sets both registers to 128 and restarts the frame.
// A cfg write also restarts the frame; write only while the block is idle.
// There is no clearing pass: line memory contents are only used once written.
// ---------------------------------------------------------------------------
`include "prewitt_edge_magnitude_top_macros.svh"

module prewitt_edge_magnitude_top
  import pem_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  // pixel stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [PIX_IN_W-1:0]    s_axis_tdata,   // [15:0] pixel_value
  input  wire logic                   s_axis_tuser,   // [0] mode
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [10:0] edge_magnitude
  output logic                        m_axis_tlast,   // last
  output logic                        m_axis_tuser    // [0] frame_done
);

  // configuration registers and clamped values in use
  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [WCMP_W-1:0] width_ext;
  logic [HCMP_W-1:0] height_ext;
  logic [WDIM_W-1:0] used_w;
  logic [ROW_W-1:0]  used_h;
  logic [COL_W-1:0]  w_last;

  // frame position of the next request
  logic [COL_W-1:0]  col_cnt;
  logic [ROW_W-1:0]  row_cnt;

  // input register stage
  logic              a_valid;
  pix_t              a_px;
  logic [COL_W-1:0]  a_col;
  logic              a_first_col;
  logic              a_last_col;
  logic              a_row_ge1;
  logic              a_row_ge2;
  logic              a_flush_row;
  logic [2*PIX_W-1:0] rd_data;     // {prev2, prev}

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  // window: left and centre columns
  column_t           win_l;
  column_t           win_c;

  // result queue
  result_t           q_slot [2];
  logic              q_rd;
  logic [1:0]        q_cnt;

  logic              in_acc;
  logic              a_adv;
  logic              pop;
  logic [1:0]        n_res;
  logic              restart;
  pix_t              px_eff;
  column_t           col_new;
  result_t           res0;
  result_t           res1;
  logic              q_wr;
  logic [2:0]        q_room;

  always_comb begin
    width_ext  = WCMP_W'(image_width);
    height_ext = HCMP_W'(image_height);
    if (width_ext < WCMP_W'(MIN_WIDTH)) begin
      used_w = WDIM_W'(MIN_WIDTH);
    end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
      used_w = WDIM_W'(MAX_WIDTH);
    end else begin
      used_w = WDIM_W'(width_ext);
    end
    if (height_ext < HCMP_W'(MIN_HEIGHT)) begin
      used_h = ROW_W'(MIN_HEIGHT);
    end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
      used_h = ROW_W'(MAX_HEIGHT);
    end else begin
      used_h = ROW_W'(height_ext);
    end
    w_last = COL_W'(used_w - WDIM_W'(1));
  end

  assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // results caused by the item in the input register
  always_comb begin
    if (a_first_col || !a_row_ge1) begin
      n_res = 2'd0;
    end else if (a_last_col) begin
      n_res = 2'd2;
    end else begin
      n_res = 2'd1;
    end
  end

  assign pop    = m_axis_tvalid && m_axis_tready;
  assign q_room = 3'd2 - 3'(q_cnt) + 3'(pop);
  assign a_adv  = a_valid && (3'(n_res) <= q_room);
  assign s_axis_tready = !a_valid || a_adv;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (s_axis_tdata > PIX_MAX || s_axis_tuser || row_cnt >= used_h) begin
      px_eff = '0;
    end else begin
      px_eff = s_axis_tdata[PIX_W-1:0];
    end
  end

  always_comb begin
    col_new.top = a_row_ge2 ? rd_data[2*PIX_W-1:PIX_W] : '0;
    col_new.mid = a_row_ge1 ? rd_data[PIX_W-1:0] : '0;
    col_new.bot = a_px;

    res0.mag        = prewitt_mag(win_l, win_c, col_new);
    res0.last       = !a_last_col;
    res0.frame_done = 1'b0;
    // right edge: the column beyond the image is zero
    res1.mag        = prewitt_mag(win_c, col_new, '0);
    res1.last       = 1'b1;
    res1.frame_done = a_flush_row;
  end

  // line memory: one read at request time, one write when the item moves on
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= line_mem[col_cnt];
    end
    if (a_adv) begin
      line_mem[a_col] <= {rd_data[PIX_W-1:0], a_px};
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_px        <= px_eff;
      a_col       <= col_cnt;
      a_first_col <= (col_cnt == '0);
      a_last_col  <= (col_cnt == w_last);
      a_row_ge1   <= (row_cnt >= ROW_W'(1));
      a_row_ge2   <= (row_cnt >= ROW_W'(2));
      a_flush_row <= (row_cnt == used_h);
    end
  end

  // control: registers, counters, input stage valid, window
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_RESET;
      image_height <= CFG_RESET;
      col_cnt      <= '0;
      row_cnt      <= '0;
      a_valid      <= 1'b0;
      win_l        <= '0;
      win_c        <= '0;
    end else if (restart) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
      col_cnt <= '0;
      row_cnt <= '0;
      win_l   <= '0;
      win_c   <= '0;
    end else begin
      if (in_acc) begin
        a_valid <= 1'b1;
        if (col_cnt == w_last) begin
          col_cnt <= '0;
          row_cnt <= (row_cnt == used_h) ? '0 : row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_cnt + COL_W'(1);
        end
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        win_l <= a_first_col ? column_t'('0) : win_c;
        win_c <= col_new;
      end
    end
  end

  // result queue, two entries
  assign q_wr = q_rd ^ q_cnt[0];

  always_ff @(posedge clk) begin
    if (a_adv) begin
      if (n_res == 2'd2) begin
        q_slot[q_wr]  <= res0;
        q_slot[!q_wr] <= res1;
      end else if (n_res == 2'd1) begin
        q_slot[q_wr]  <= res0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd  <= 1'b0;
      q_cnt <= '0;
    end else begin
      if (pop) begin
        q_rd <= !q_rd;
      end
      q_cnt <= q_cnt - 2'(pop) + (a_adv ? n_res : 2'd0);
    end
  end

  assign m_axis_tvalid = (q_cnt != '0);
  assign m_axis_tdata  = OUT_TDATA_W'(q_slot[q_rd].mag);
  assign m_axis_tlast  = q_slot[q_rd].last;
  assign m_axis_tuser  = q_slot[q_rd].frame_done;

  `PEM_ASSERT_NOW(a_q_cnt_bound, 1'b1, q_cnt <= 2'd2)
  `PEM_ASSERT_NEXT(a_stage_held, a_valid && !a_adv && !restart, a_valid)
  `PEM_ASSERT_NOW(a_frame_done_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `PEM_ASSERT_NOW(a_col_in_range, 1'b1, col_cnt <= w_last)
  `PEM_ASSERT_NOW(a_row_in_range, 1'b1, row_cnt <= used_h)

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming Prewitt edge magnitude block.
// Pixels go in on the request stream under random sender and receiver
// stalls. A scoreboard keeps its own line rows and window, predicts every
// result of each accepted pixel and checks the result stream in order.
// Image sizes range from the smallest to the largest, out-of-range register
// values included, with whole and broken-off frames.
// ---------------------------------------------------------------------------
module tb;
  import pem_pkg::*;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam int ITEM_TARGET = 1850;
  localparam int CALM_FROM   = 1650;
  localparam int STALL_LIMIT = 500;

  // {mode, pixel_value}; sized for two 4 x 2 frames, each with its flush row
  localparam logic [16:0] DIRECTED_ITEMS [0:23] = '{
    {MODE_PIXEL, 16'h00FF}, {MODE_PIXEL, 16'h00FF}, {MODE_PIXEL, 16'h0000},
    {MODE_PIXEL, 16'hFFFF},
    {MODE_PIXEL, 16'h00FF}, {MODE_PIXEL, 16'h0100}, {MODE_PIXEL, 16'h0000},
    {MODE_FLUSH, 16'h00FF},
    {MODE_FLUSH, 16'h0000}, {MODE_PIXEL, 16'h00FF}, {MODE_FLUSH, 16'hFFFF},
    {MODE_PIXEL, 16'h0080},
    {MODE_PIXEL, 16'h0000}, {MODE_PIXEL, 16'h0000}, {MODE_PIXEL, 16'h00FF},
    {MODE_PIXEL, 16'h00FF},
    {MODE_PIXEL, 16'h00FF}, {MODE_PIXEL, 16'h00FF}, {MODE_PIXEL, 16'h0000},
    {MODE_PIXEL, 16'h0000},
    {MODE_FLUSH, 16'h0000}, {MODE_FLUSH, 16'h0000}, {MODE_FLUSH, 16'h0000},
    {MODE_FLUSH, 16'h0000}
  };

  class edge_scoreboard;
    pix_t        row_above [MAX_WIDTH];
    pix_t        row_above2 [MAX_WIDTH];
    column_t     left_col;
    column_t     centre_col;
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned width_reg;
    int unsigned height_reg;
    result_t     pending [$];
    int unsigned fail_count;

    function new();
      foreach (row_above[i]) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
      width_reg  = 128;
      height_reg = 128;
      fail_count = 0;
      restart();
    endfunction

    function void restart();
      col_pos    = 0;
      row_pos    = 0;
      left_col   = '0;
      centre_col = '0;
    endfunction

    function int unsigned active_width();
      if (width_reg < MIN_WIDTH) return MIN_WIDTH;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned active_height();
      if (height_reg < MIN_HEIGHT) return MIN_HEIGHT;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = value;
        REG_IMAGE_HEIGHT: height_reg = value;
        default: ;
      endcase
      restart();
    endfunction

    function logic [MAG_W-1:0] prewitt_sum(column_t lc, column_t cc, column_t rc);
      int left_sum, right_sum, bot_sum, top_sum, gx, gy;
      left_sum  = lc.top + lc.mid + lc.bot;
      right_sum = rc.top + rc.mid + rc.bot;
      bot_sum   = lc.bot + cc.bot + rc.bot;
      top_sum   = lc.top + cc.top + rc.top;
      gx = left_sum - right_sum;
      gy = bot_sum - top_sum;
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      return MAG_W'(gx + gy);
    endfunction

    // one accepted pixel request: update rows and window, queue its results
    function void note_request(logic mode, logic [PIX_IN_W-1:0] value);
      int unsigned w, h, r, c;
      pix_t        px;
      column_t     incoming;
      result_t     res;
      w = active_width();
      h = active_height();
      r = (row_pos > h) ? h : row_pos;
      c = (col_pos >= w) ? w - 1 : col_pos;
      // flush items, over-range values and the whole flush row are zero pixels
      px = (value > PIX_MAX || mode == MODE_FLUSH || r >= h) ? '0 : value[PIX_W-1:0];
      incoming.top = (r >= 2) ? row_above2[c] : '0;
      incoming.mid = (r >= 1) ? row_above[c] : '0;
      incoming.bot = px;
      row_above2[c] = row_above[c];
      row_above[c]  = px;
      if (c == 0) begin
        left_col   = '0;
        centre_col = incoming;
      end else begin
        if (r >= 1) begin
          res.mag        = prewitt_sum(left_col, centre_col, incoming);
          res.last       = (c != w - 1);
          res.frame_done = 1'b0;
          pending.push_back(res);
        end
        left_col   = centre_col;
        centre_col = incoming;
        // right edge: the column beyond the image is zero
        if (c == w - 1 && r >= 1) begin
          res.mag        = prewitt_sum(left_col, centre_col, '0);
          res.last       = 1'b1;
          res.frame_done = (r == h);
          pending.push_back(res);
        end
      end
      c++;
      if (c >= w) begin
        c = 0;
        r = (r >= h) ? 0 : r + 1;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch: %s got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, magnitude", got.mag, -1);
      end else begin
        want = pending.pop_front();
        if (got.mag !== want.mag) report_mismatch("edge_magnitude", got.mag, want.mag);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
        if (got.frame_done !== want.frame_done)
          report_mismatch("frame_done", got.frame_done, want.frame_done);
      end
    endtask

    task report_leftovers();
      result_t want;
      while (pending.size() != 0) begin
        want = pending.pop_front();
        report_mismatch("missing result", -1, want.mag);
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_IN_W-1:0]    s_axis_tdata = '0;   // [15:0] pixel_value
  logic                   s_axis_tuser = 1'b0; // [0] mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [10:0] edge_magnitude
  logic                   m_axis_tlast;        // last
  logic                   m_axis_tuser;        // [0] frame_done

  edge_scoreboard board;
  bit             quiet = 1'b0;
  int             sent_count = 0;
  int             results_seen = 0;
  int             settings_run = 0;
  int             idle_cycles = 0;

  prewitt_edge_magnitude_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: stall bursts of random length
  always begin
    @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_result('{mag: m_axis_tdata[MAG_W-1:0], last: m_axis_tlast,
                           frame_done: m_axis_tuser});
      results_seen++;
    end
    if (!rst && s_axis_tvalid && s_axis_tready)
      board.note_request(s_axis_tuser, s_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles with no transfer", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [PIX_IN_W-1:0] random_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return PIX_IN_W'($urandom_range(0, 255));
    if (sel < 75) return $urandom_range(0, 1) ? PIX_MAX : '0;
    if (sel < 88) return PIX_IN_W'($urandom);
    if (sel < 96) return PIX_IN_W'($urandom_range(256, 511));
    return '1;
  endfunction

  function automatic logic random_mode(bit in_flush_row);
    if (in_flush_row) return ($urandom_range(0, 99) < 85) ? MODE_FLUSH : MODE_PIXEL;
    return ($urandom_range(0, 99) < 5) ? MODE_FLUSH : MODE_PIXEL;
  endfunction

  // leaves s_axis_tvalid high after the request is taken
  task automatic send_pixel(input logic mode, input logic [PIX_IN_W-1:0] value);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    // pixels of row 0 leave nothing behind to wait for
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.set_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // new image size, then count pixels in raster order from a fresh frame
  task automatic run_image(input logic [CFG_W-1:0] wval, input logic [CFG_W-1:0] hval,
                           input int count);
    int unsigned w, h, r, c;
    if ($urandom_range(0, 1)) begin
      write_register(REG_IMAGE_WIDTH, wval);
      write_register(REG_IMAGE_HEIGHT, hval);
    end else begin
      write_register(REG_IMAGE_HEIGHT, hval);
      write_register(REG_IMAGE_WIDTH, wval);
    end
    w = board.active_width();
    h = board.active_height();
    r = 0;
    c = 0;
    for (int i = 0; i < count; i++) begin
      // no idling over the closing stretch of the run
      if (sent_count >= CALM_FROM) quiet = 1'b1;
      send_pixel(random_mode(r >= h), random_pixel());
      c++;
      if (c == w) begin
        c = 0;
        r = (r == h) ? 0 : r + 1;
      end
    end
    drain();
    settings_run++;
  endtask

  initial begin
    logic [CFG_W-1:0] wval, hval;
    int unsigned      w, h, frame_len, count;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_register(REG_IMAGE_WIDTH, 8'd4);
    write_register(REG_IMAGE_HEIGHT, 8'd2);
    foreach (DIRECTED_ITEMS[i]) send_pixel(DIRECTED_ITEMS[i][16], DIRECTED_ITEMS[i][15:0]);
    drain();
    settings_run++;

    run_image(8'd0, 8'd1, 27);      // clamped to 3 x 2
    run_image(8'd255, 8'd2, 384);   // clamped to the widest row
    run_image(8'd3, 8'd255, 387);   // clamped to the tallest frame
    run_image(8'd128, 8'd128, 140); // broken off in row 1
    run_image(8'd2, 8'd0, 18);

    while (sent_count < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       wval = CFG_W'($urandom_range(0, 2));
        1:       wval = CFG_W'($urandom_range(13, 24));
        default: wval = CFG_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       hval = CFG_W'($urandom_range(0, 1));
        1:       hval = CFG_W'($urandom_range(9, 12));
        default: hval = CFG_W'($urandom_range(2, 8));
      endcase
      w = (wval < MIN_WIDTH) ? MIN_WIDTH : wval;
      h = (hval < MIN_HEIGHT) ? MIN_HEIGHT : hval;
      frame_len = w * (h + 1);
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, frame_len - 1);
      else count = frame_len * $urandom_range(1, 3);
      if (count > ITEM_TARGET - sent_count) count = ITEM_TARGET - sent_count;
      quiet = (sent_count >= CALM_FROM) || ($urandom_range(0, 4) == 0);
      run_image(wval, hval, count);
    end

    repeat (10) @(posedge clk);
    board.report_leftovers();
    $display("%0d pixel requests and %0d results checked over %0d image settings,",
             sent_count, results_seen, settings_run);
    $display("widths 3 to 128 and heights 2 to 128, clamped values and cut frames included");
    if (board.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", board.fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/pem_pkg.sv
rtl/prewitt_edge_magnitude_top.sv
tb/tb.sv
